>>> hw/rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared constants for the two-button debounce and long-press qualifier.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int PORT_W      = 8;
   localparam int CSR_INDEX_W = 2;

   // active-low bit positions in the port word
   localparam int PWR_BIT  = 0;
   localparam int MENU_BIT = 1;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_INIT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd2000;

endpackage

>>> hw/rtl/button_debounce_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces the power and menu buttons from timestamped port words and
// reports menu press, power short press and power long press events.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register and its result is
// presented from the result register, which can hold back the next word.
// Throughput: one word per cycle unless rsp_ready stalls; the button state
// updates in a single pass between the input register and the result register.
// Reset: synchronous, active high; clears the button state, disarms the
// block and restores debounce 50 ms and long press 2000 ms.
module button_debounce_long_press
   import bdlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [PORT_W-1:0]      req_port_sample,
   input  logic [TIME_W-1:0]      req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_menu_press,
   output logic                   rsp_power_short,
   output logic                   rsp_power_long,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic [CFG_W-1:0] debounce_ff, long_press_ff;

   logic              in_valid_ff;
   logic              in_op_ff;
   logic [PORT_W-1:0] in_port_ff;
   logic [TIME_W-1:0] in_now_ff;

   logic              armed_ff, armed_in;
   logic              menu_raw_ff, menu_raw_in;
   logic              menu_stable_ff, menu_stable_in;
   logic [TIME_W-1:0] menu_change_ff, menu_change_in;
   logic              power_raw_ff, power_raw_in;
   logic              power_stable_ff, power_stable_in;
   logic [TIME_W-1:0] power_change_ff, power_change_in;
   logic [TIME_W-1:0] power_press_ff, power_press_in;
   logic              long_reported_ff, long_reported_in;

   logic rsp_valid_ff;
   logic menu_ev_ff, menu_ev_in;
   logic short_ev_ff, short_ev_in;
   logic long_ev_ff, long_ev_in;

   logic              advance;
   logic              pwr, menu;
   logic [TIME_W-1:0] menu_elapsed, power_elapsed, press_elapsed;
   logic [TIME_W-1:0] debounce_ext, long_press_ext;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_menu_press  = menu_ev_ff;
   assign rsp_power_short = short_ev_ff;
   assign rsp_power_long  = long_ev_ff;

   assign pwr  = !in_port_ff[PWR_BIT];
   assign menu = !in_port_ff[MENU_BIT];

   assign debounce_ext   = {{(TIME_W-CFG_W){1'b0}}, debounce_ff};
   assign long_press_ext = {{(TIME_W-CFG_W){1'b0}}, long_press_ff};
   assign menu_elapsed   = in_now_ff - menu_change_ff;
   assign power_elapsed  = in_now_ff - power_change_ff;
   assign press_elapsed  = in_now_ff - power_press_ff;

   always_comb begin
      armed_in         = armed_ff;
      menu_raw_in      = menu_raw_ff;
      menu_stable_in   = menu_stable_ff;
      menu_change_in   = menu_change_ff;
      power_raw_in     = power_raw_ff;
      power_stable_in  = power_stable_ff;
      power_change_in  = power_change_ff;
      power_press_in   = power_press_ff;
      long_reported_in = long_reported_ff;
      menu_ev_in       = 1'b0;
      short_ev_in      = 1'b0;
      long_ev_in       = 1'b0;

      if (in_op_ff == OP_INIT) begin
         armed_in         = 1'b1;
         power_raw_in     = pwr;
         power_stable_in  = pwr;
         power_change_in  = in_now_ff;
         power_press_in   = pwr ? in_now_ff : '0;
         long_reported_in = 1'b0;
         menu_raw_in      = menu;
         menu_stable_in   = menu;
         menu_change_in   = in_now_ff;
      end else if (armed_ff) begin
         // power button
         if (pwr != power_raw_ff) begin
            power_raw_in    = pwr;
            power_change_in = in_now_ff;
         end else if (power_stable_ff != power_raw_ff) begin
            if (power_elapsed >= debounce_ext) begin
               power_stable_in  = power_raw_ff;
               long_reported_in = 1'b0;
               if (power_raw_ff) begin
                  power_press_in = in_now_ff;
               end else begin
                  power_press_in = '0;
                  short_ev_in    = !long_reported_ff;
               end
            end
         end else if (power_stable_ff && !long_reported_ff && power_press_ff != '0 &&
                      press_elapsed >= long_press_ext) begin
            long_reported_in = 1'b1;
            long_ev_in       = 1'b1;
         end

         // menu button
         if (menu != menu_raw_ff) begin
            menu_raw_in    = menu;
            menu_change_in = in_now_ff;
         end else if (menu_stable_ff != menu_raw_ff &&
                      menu_elapsed >= debounce_ext) begin
            menu_stable_in = menu_raw_ff;
            menu_ev_in     = menu_raw_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEBOUNCE:   debounce_ff   <= csr_wdata;
            REG_LONG_PRESS: long_press_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_port_ff <= req_port_sample;
         in_now_ff  <= req_now_ms;
      end
   end

   // button state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         menu_raw_ff      <= 1'b0;
         menu_stable_ff   <= 1'b0;
         menu_change_ff   <= '0;
         power_raw_ff     <= 1'b0;
         power_stable_ff  <= 1'b0;
         power_change_ff  <= '0;
         power_press_ff   <= '0;
         long_reported_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            armed_ff         <= armed_in;
            menu_raw_ff      <= menu_raw_in;
            menu_stable_ff   <= menu_stable_in;
            menu_change_ff   <= menu_change_in;
            power_raw_ff     <= power_raw_in;
            power_stable_ff  <= power_stable_in;
            power_change_ff  <= power_change_in;
            power_press_ff   <= power_press_in;
            long_reported_ff <= long_reported_in;
         end
         // drop the result word once taken unless a new one replaces it
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         menu_ev_ff  <= menu_ev_in;
         short_ev_ff <= short_ev_in;
         long_ev_ff  <= long_ev_in;
      end
   end

   a_short_long_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(short_ev_ff && long_ev_ff))
      else $error("short and long press in one word");

   a_long_needs_press: assert property (@(posedge clock) disable iff (reset)
      long_reported_ff |-> power_stable_ff)
      else $error("long press flagged while power is not stably pressed");

   a_unarmed_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !armed_ff) |-> !(menu_ev_ff || short_ev_ff || long_ev_ff))
      else $error("event reported before arming");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_debounce_long_press. A table of port words
// covers arming, debounce edges, long and short presses and timestamp wrap.
// Phases of random press, bounce and hold sequences follow under several
// debounce and long-press settings. Every result word is checked in order
// against a table entry or an in-bench model of the two button qualifiers.
// ----------------------------------------------------------------------------
module tb;
   import bdlp_pkg::*;

   localparam int N_DIRECTED       = 26;
   localparam int N_PHASES         = 8;
   localparam int WORDS_PER_PHASE  = 106;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic menu_press;
      logic power_short;
      logic power_long;
   } btn_result_type;

   typedef struct packed {
      logic              op;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
      logic              typed;
      btn_result_type    want;
   } stim_row_type;

   localparam btn_result_type QUIET = '0;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic                   req_op          = OP_POLL;
   logic [PORT_W-1:0]      req_port_sample = '1;
   logic [TIME_W-1:0]      req_now_ms      = '0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic                   rsp_menu_press;
   logic                   rsp_power_short;
   logic                   rsp_power_long;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = REG_DEBOUNCE;
   logic [CFG_W-1:0]       csr_wdata       = '0;

   // button model state, starting from the reset state
   logic              armed_m       = 1'b0;
   logic              pwr_raw_m     = 1'b0;
   logic              pwr_stable_m  = 1'b0;
   logic              long_seen_m   = 1'b0;
   logic              menu_raw_m    = 1'b0;
   logic              menu_stable_m = 1'b0;
   logic [TIME_W-1:0] pwr_change_m  = '0;
   logic [TIME_W-1:0] pwr_press_m   = '0;
   logic [TIME_W-1:0] menu_change_m = '0;
   logic [CFG_W-1:0]  debounce_len  = DEBOUNCE_RESET;
   logic [CFG_W-1:0]  long_press_ms = LONG_PRESS_RESET;

   btn_result_type expected_events [$];
   btn_result_type got;
   btn_result_type want;
   int unsigned    mismatch_count = 0;
   logic           hold_off_req   = 1'b0;
   logic           hold_done      = 1'b0;
   logic           gaps_on        = 1'b1;
   logic           stalls_on      = 1'b1;

   // port words are active low: FF idle, FE power, FD menu, FC both
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{OP_POLL, 8'h00, 32'd100,        1'b1, QUIET},
      '{OP_POLL, 8'hFF, 32'hFFFF_FFFF,  1'b1, QUIET},
      '{OP_INIT, 8'hFF, 32'd0,          1'b1, QUIET},
      '{OP_POLL, 8'hFC, 32'd10,         1'b0, QUIET},
      '{OP_POLL, 8'hFC, 32'd59,         1'b0, QUIET},
      '{OP_POLL, 8'hFC, 32'd60,         1'b0, QUIET},
      '{OP_POLL, 8'h00, 32'd2059,       1'b0, QUIET},
      '{OP_POLL, 8'hFC, 32'd2060,       1'b0, QUIET},
      '{OP_POLL, 8'hFC, 32'd5000,       1'b0, QUIET},
      '{OP_POLL, 8'hFF, 32'd5001,       1'b0, QUIET},
      '{OP_POLL, 8'h03, 32'd5051,       1'b0, QUIET},
      '{OP_POLL, 8'hFE, 32'd6000,       1'b0, QUIET},
      '{OP_POLL, 8'hFE, 32'd6050,       1'b0, QUIET},
      '{OP_POLL, 8'hFF, 32'd6100,       1'b0, QUIET},
      '{OP_POLL, 8'hFF, 32'd6150,       1'b0, QUIET},
      '{OP_INIT, 8'hFF, 32'hFFFF_FFF0,  1'b1, QUIET},
      '{OP_POLL, 8'hFD, 32'hFFFF_FFF5,  1'b0, QUIET},
      '{OP_POLL, 8'hFD, 32'h0000_0027,  1'b0, QUIET},
      '{OP_INIT, 8'hFF, 32'hFFFF_FFCE,  1'b1, QUIET},
      '{OP_POLL, 8'hFE, 32'hFFFF_FFCE,  1'b0, QUIET},
      '{OP_POLL, 8'hFE, 32'd0,          1'b0, QUIET},
      '{OP_POLL, 8'hFE, 32'd3000,       1'b0, QUIET},
      '{OP_POLL, 8'hFF, 32'd3001,       1'b0, QUIET},
      '{OP_POLL, 8'hFF, 32'd3051,       1'b0, QUIET},
      '{OP_INIT, 8'hFE, 32'd7000,       1'b1, QUIET},
      '{OP_POLL, 8'hFE, 32'd9000,       1'b0, QUIET}
   };

   button_debounce_long_press uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_port_sample (req_port_sample),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_menu_press  (rsp_menu_press),
      .rsp_power_short (rsp_power_short),
      .rsp_power_long  (rsp_power_long),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic btn_result_type qualify_buttons(input logic op,
         input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now);
      btn_result_type    r;
      logic              pwr_dn;
      logic              menu_dn;
      logic [TIME_W-1:0] held;
      r       = QUIET;
      pwr_dn  = ~port[PWR_BIT];
      menu_dn = ~port[MENU_BIT];
      if (op == OP_INIT) begin
         armed_m       = 1'b1;
         pwr_raw_m     = pwr_dn;
         pwr_stable_m  = pwr_dn;
         pwr_change_m  = now;
         pwr_press_m   = pwr_dn ? now : '0;
         long_seen_m   = 1'b0;
         menu_raw_m    = menu_dn;
         menu_stable_m = menu_dn;
         menu_change_m = now;
         return r;
      end
      if (!armed_m)
         return r;
      // power first, then menu
      if (pwr_dn != pwr_raw_m) begin
         pwr_raw_m    = pwr_dn;
         pwr_change_m = now;
      end else if (pwr_stable_m != pwr_raw_m) begin
         held = now - pwr_change_m;
         if (held >= debounce_len) begin
            pwr_stable_m = pwr_raw_m;
            if (pwr_stable_m) begin
               pwr_press_m = now;
            end else begin
               r.power_short = ~long_seen_m;
               pwr_press_m   = '0;
            end
            long_seen_m = 1'b0;
         end
      end else begin
         held = now - pwr_press_m;
         // a press time of zero skips the long check
         if (pwr_stable_m && !long_seen_m && pwr_press_m != '0 &&
             held >= long_press_ms) begin
            long_seen_m  = 1'b1;
            r.power_long = 1'b1;
         end
      end
      if (menu_dn != menu_raw_m) begin
         menu_raw_m    = menu_dn;
         menu_change_m = now;
      end else if (menu_stable_m != menu_raw_m) begin
         held = now - menu_change_m;
         if (held >= debounce_len) begin
            menu_stable_m = menu_raw_m;
            r.menu_press  = menu_raw_m;
         end
      end
      return r;
   endfunction

   // leaves req_valid high so the next word can follow back to back
   task automatic send_word(input logic op, input logic [PORT_W-1:0] port,
         input logic [TIME_W-1:0] now, input logic typed, input btn_result_type typed_want);
      btn_result_type r;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_port_sample <= port;
      req_now_ms      <= now;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      r = qualify_buttons(op, port, now);
      expected_events.push_back(typed ? typed_want : r);
   endtask

   task automatic drain_events();
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
         input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (index == REG_DEBOUNCE)
         debounce_len = data;
      else
         long_press_ms = data;
   endtask

   initial begin
      stim_row_type      row;
      int unsigned       deb;
      int unsigned       lng;
      int unsigned       base;
      int unsigned       pick;
      int unsigned       step;
      logic              pwr_lvl;
      logic              menu_lvl;
      logic              op;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_word(row.op, row.port, row.now, row.typed, row.want);
      end
      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain_events();
         case (phase)
            0: begin deb = 0; lng = 0; end
            1: begin deb = 65535; lng = 65535; end
            2: begin deb = 5; lng = 40; end
            3: begin deb = $urandom_range(0, 30); lng = $urandom_range(0, 300); end
            4: begin deb = 1; lng = 65535; end
            5: begin deb = 65535; lng = 1; end
            6: begin deb = $urandom_range(0, 65535); lng = $urandom_range(0, 65535); end
            default: begin deb = 20; lng = 150; end
         endcase
         write_reg(REG_LONG_PRESS, lng[CFG_W-1:0]);
         write_reg(REG_DEBOUNCE, deb[CFG_W-1:0]);
         csr_valid <= 1'b0;
         base      = (deb == 0) ? 1 : deb;
         gaps_on   = (phase != N_PHASES - 1);
         stalls_on = (phase != N_PHASES - 1);
         // back up the block once while words keep coming
         if (phase == 2)
            hold_off_req = 1'b1;
         if ($urandom_range(0, 1) == 1)
            now = $urandom;
         else
            now = '1 - $urandom_range(0, 20 * base);
         pwr_lvl  = 1'($urandom_range(0, 1));
         menu_lvl = 1'($urandom_range(0, 1));
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == 0 || $urandom_range(0, 49) == 0)
               op = OP_INIT;
            else
               op = OP_POLL;
            if ($urandom_range(0, 5) == 0)
               pwr_lvl = ~pwr_lvl;
            if ($urandom_range(0, 5) == 0)
               menu_lvl = ~menu_lvl;
            // land on the debounce and hold thresholds often
            pick = $urandom_range(0, 99);
            if (pick < 10)
               step = 0;
            else if (pick < 30)
               step = $urandom_range(1, base);
            else if (pick < 45)
               step = deb;
            else if (pick < 50)
               step = (deb == 0) ? 0 : deb - 1;
            else if (pick < 60)
               step = lng;
            else if (pick < 63)
               step = (lng == 0) ? 0 : lng - 1;
            else if (pick < 93)
               step = $urandom_range(0, 2 * base);
            else if (pick < 98)
               step = $urandom_range(0, lng + 2 * base);
            else
               step = $urandom;
            if (pick == 99 && $urandom_range(0, 1) == 1)
               now = '0;
            else
               now = now + step;
            port           = PORT_W'($urandom_range(0, 255));
            port[PWR_BIT]  = ~pwr_lvl;
            port[MENU_BIT] = ~menu_lvl;
            if (gaps_on && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 7)) @(posedge clock);
            end
            send_word(op, port, now, 1'b0, QUIET);
            if (n % 30 == 29 && phase != N_PHASES - 1) begin
               gaps_on   = ($urandom_range(0, 2) != 0);
               stalls_on = ($urandom_range(0, 2) != 0);
            end
         end
      end
      drain_events();
      if (mismatch_count == 0)
         $display("button_debounce_long_press: match");
      else
         $display("button_debounce_long_press: mismatch");
      $finish;
   end

   initial begin
      forever begin
         if (hold_off_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_menu_press, rsp_power_short, rsp_power_long};
         if (expected_events.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected result word menu %b short %b long %b",
                        $time, got.menu_press, got.power_short, got.power_long);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            if (got.menu_press !== want.menu_press ||
                got.power_short !== want.power_short ||
                got.power_long !== want.power_long) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: menu_press exp %b got %b, power_short exp %b got %b, %s %b %s %b",
                           $time, want.menu_press, got.menu_press, want.power_short,
                           got.power_short, "power_long exp", want.power_long, "got",
                           got.power_long);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("button_debounce_long_press: mismatch");
      $finish;
   end

endmodule
